>>> rtl/ssal_pkg.sv
// Shared types, widths and codes of the sampled suffix array lookup.
package ssal_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 65536;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int POS_W    = 16;
   localparam int VAL_W    = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int RATE_W   = 9;
   localparam int TEXT_W   = 17;

   // Quotients come from a multiply by ceil(2^RECIP_SHIFT / rate).
   localparam int RECIP_SHIFT = POS_W + RATE_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_CNT_W = $clog2(RECIP_SHIFT);
   localparam int PROD_W      = POS_W + RECIP_W;
   localparam int QD_W        = POS_W + RATE_W;

   localparam int REQ_DATA_W = POS_W + VAL_W;
   localparam int RSP_DATA_W = POS_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PSI   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WALK  = 2'd2;

   localparam logic REG_SAMPLE_RATE = 1'b0;
   localparam logic REG_TEXT_SIZE   = 1'b1;

   localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 9'd32;
   localparam logic [TEXT_W-1:0] TEXT_SIZE_RESET   = 17'd65536;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_PSI       = 2'd1,
      OP_QUERY     = 2'd2,
      OP_BAD_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   value;
   } cmd_type;

   // Positions are 16 bits wide, so no store needs more than 2^16 entries.
   function automatic int store_depth(input int max_entries);
      int depth;
      depth = (max_entries < (1 << POS_W)) ? max_entries : (1 << POS_W);
      return depth;
   endfunction

endpackage

>>> rtl/ssal_recip.sv
// Iterative unit that forms ceil(2^RECIP_SHIFT / rate), one quotient bit per cycle.
module ssal_recip (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ssal_pkg::RATE_W-1:0]      rate,
   output logic                             busy,
   output logic [ssal_pkg::RECIP_W-1:0]     recip
);

   localparam logic [ssal_pkg::RECIP_CNT_W-1:0] LAST_BIT =
      ssal_pkg::RECIP_CNT_W'(ssal_pkg::RECIP_SHIFT - 1);

   logic                                  busy_ff;
   logic [ssal_pkg::RECIP_CNT_W-1:0]      cnt_ff;
   logic [ssal_pkg::RATE_W-1:0]           rem_ff, rem_in;
   logic [ssal_pkg::RECIP_SHIFT-1:0]      quo_ff;
   logic [ssal_pkg::RATE_W:0]             shifted;
   logic                                  quo_bit;

   // The dividend is 2^RECIP_SHIFT - 1, all ones; floor of that plus one is the ceiling.
   always_comb begin
      shifted = {rem_ff, 1'b1};
      quo_bit = (shifted >= {1'b0, rate});
      if (quo_bit) begin
         rem_in = ssal_pkg::RATE_W'(shifted - {1'b0, rate});
      end else begin
         rem_in = shifted[ssal_pkg::RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[ssal_pkg::RECIP_SHIFT-2:0], quo_bit};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy  = busy_ff;
   assign recip = {1'b0, quo_ff} + ssal_pkg::RECIP_W'(1);

endmodule

>>> rtl/ssal_front.sv
// Front end: takes request words, sorts them by kind and screens positions.
module ssal_front #(
   parameter int MAX_ENTRIES = ssal_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ssal_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [ssal_pkg::KIND_W-1:0]        req_tuser,
   input  logic                               accept_en,
   input  logic                               queue_full,
   input  logic [ssal_pkg::TEXT_W-1:0]        text_size,
   output logic                               push,
   output ssal_pkg::cmd_type                  cmd
);

   localparam int DEPTH = ssal_pkg::store_depth(MAX_ENTRIES);
   localparam logic [ssal_pkg::TEXT_W-1:0] POS_LIMIT = ssal_pkg::TEXT_W'(DEPTH);

   logic [ssal_pkg::POS_W-1:0] position;
   logic [ssal_pkg::VAL_W-1:0] value;
   logic                       in_store;
   logic                       in_text;
   logic                       keep;

   assign position = req_tdata[ssal_pkg::POS_W-1:0];
   assign value    = req_tdata[ssal_pkg::REQ_DATA_W-1:ssal_pkg::POS_W];
   assign in_store = ({1'b0, position} < POS_LIMIT);
   assign in_text  = ({1'b0, position} < text_size);

   assign req_tready = accept_en && !queue_full;

   always_comb begin
      cmd.position = position;
      cmd.value    = value;
      case (req_tuser)
         ssal_pkg::KIND_LOAD: begin
            cmd.op = ssal_pkg::OP_LOAD;
            keep   = 1'b1;
         end
         ssal_pkg::KIND_PSI: begin
            cmd.op = ssal_pkg::OP_PSI;
            keep   = in_store;
         end
         ssal_pkg::KIND_QUERY: begin
            cmd.op = (in_store && in_text) ? ssal_pkg::OP_QUERY : ssal_pkg::OP_BAD_QUERY;
            keep   = 1'b1;
         end
         default: begin
            cmd.op = ssal_pkg::OP_LOAD;
            keep   = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && req_tready && keep;

endmodule

>>> rtl/ssal_queue.sv
// Small command queue between the front end and the walk engine.
module ssal_queue #(
   parameter int DEPTH = ssal_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssal_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output ssal_pkg::cmd_type  head_cmd,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ssal_pkg::cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/ssal_back.sv
// Back end: psi and sample stores, load indexing and the psi walk engine.
module ssal_back #(
   parameter int MAX_ENTRIES = ssal_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssal_pkg::cmd_type                  head_cmd,
   input  logic                               empty,
   output logic                               pop,
   input  logic [ssal_pkg::RATE_W-1:0]        rate,
   input  logic [ssal_pkg::RECIP_W-1:0]       recip,
   input  logic [ssal_pkg::TEXT_W-1:0]        text_size,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ssal_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [ssal_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int DEPTH = ssal_pkg::store_depth(MAX_ENTRIES);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ssal_pkg::TEXT_W-1:0] POS_LIMIT = ssal_pkg::TEXT_W'(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_MUL    = 5'b00010,
      S_QD     = 5'b00100,
      S_DECIDE = 5'b01000,
      S_SAMPLE = 5'b10000
   } state_type;

   logic [ssal_pkg::POS_W-1:0] psi_mem    [DEPTH];
   logic [ssal_pkg::VAL_W-1:0] sample_mem [DEPTH];

   state_type                          state_ff, state_in;
   logic [ssal_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [ssal_pkg::VAL_W-1:0]         val_ff, val_in;
   logic                               is_load_ff, is_load_in;
   logic [ssal_pkg::TEXT_W-1:0]        steps_ff, steps_in;
   logic [ssal_pkg::TEXT_W-1:0]        load_count_ff, load_count_in;
   logic [ssal_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [ssal_pkg::POS_W-1:0]         q_ff, q_in;
   logic [ssal_pkg::QD_W-1:0]          qd_ff, qd_in;
   logic [ssal_pkg::POS_W-1:0]         psi_rd_ff;
   logic [ssal_pkg::VAL_W-1:0]         sample_rd_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ssal_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [ssal_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                               out_free;
   logic                               psi_we;
   logic                               sample_we;
   logic [ssal_pkg::POS_W-1:0]         div_x;
   logic                               divisible;
   logic [ssal_pkg::TEXT_W-1:0]        sa_wide;
   logic [ssal_pkg::TEXT_W-1:0]        result_wide;
   logic                               next_out;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign div_x     = is_load_ff ? load_count_ff[ssal_pkg::POS_W-1:0] : pos_ff;
   assign divisible = (div_x == qd_ff[ssal_pkg::POS_W-1:0]);
   assign sa_wide   = {1'b0, sample_rd_ff};
   assign next_out  = ({1'b0, psi_rd_ff} >= text_size) || ({1'b0, psi_rd_ff} >= POS_LIMIT);

   always_comb begin
      if (sa_wide < steps_ff) begin
         result_wide = text_size - (steps_ff - sa_wide);
      end else begin
         result_wide = sa_wide - steps_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      is_load_in    = is_load_ff;
      steps_in      = steps_ff;
      load_count_in = load_count_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      qd_in         = qd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      psi_we        = 1'b0;
      sample_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               case (head_cmd.op)
                  ssal_pkg::OP_PSI: begin
                     pop    = 1'b1;
                     psi_we = 1'b1;
                  end
                  ssal_pkg::OP_LOAD: begin
                     pop = 1'b1;
                     if ((load_count_ff < text_size) && (load_count_ff < POS_LIMIT)) begin
                        is_load_in = 1'b1;
                        val_in     = head_cmd.value;
                        state_in   = S_MUL;
                     end
                  end
                  ssal_pkg::OP_QUERY: begin
                     if (out_free) begin
                        pop        = 1'b1;
                        is_load_in = 1'b0;
                        pos_in     = head_cmd.position;
                        steps_in   = '0;
                        state_in   = S_MUL;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = ssal_pkg::STATUS_RANGE;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in  = {{ssal_pkg::RECIP_W{1'b0}}, div_x} *
                       {{ssal_pkg::POS_W{1'b0}}, recip};
            state_in = S_QD;
         end
         S_QD: begin
            q_in     = prod_ff[ssal_pkg::RECIP_SHIFT +: ssal_pkg::POS_W];
            qd_in    = {{ssal_pkg::RATE_W{1'b0}}, prod_ff[ssal_pkg::RECIP_SHIFT +: ssal_pkg::POS_W]} *
                       {{ssal_pkg::POS_W{1'b0}}, rate};
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (is_load_ff) begin
               sample_we     = divisible;
               load_count_in = load_count_ff + 1'b1;
               state_in      = S_IDLE;
            end else if (divisible) begin
               state_in = S_SAMPLE;
            end else if (steps_ff >= text_size || next_out) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = ssal_pkg::STATUS_WALK;
               state_in      = S_IDLE;
            end else begin
               pos_in   = psi_rd_ff;
               steps_in = steps_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_SAMPLE: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = result_wide[ssal_pkg::RSP_DATA_W-1:0];
            rsp_status_in = ssal_pkg::STATUS_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Both stores have one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (psi_we) begin
         psi_mem[head_cmd.position[AW-1:0]] <= head_cmd.value;
      end
      psi_rd_ff <= psi_mem[pos_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sample_we) begin
         sample_mem[q_ff[AW-1:0]] <= val_ff;
      end
      sample_rd_ff <= sample_mem[q_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      is_load_ff    <= is_load_in;
      steps_ff      <= steps_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      qd_ff         <= qd_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> rtl/sampled_suffix_array_lookup.sv
// Top level of the sampled suffix array lookup with psi walk.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     tdata: position, value; tuser: kind
//   rsp      out        rsp_tvalid/tready     tdata: suffix_position; tuser: status
//   csr      in         csr_psel/penable      reg 0 sample_rate at 0x0, reg 1 text_size at 0x4
//
// A psi write is done in the idle state of the walk engine, and a load passes through
// the multiply, quotient and decide states. A query passes through those same states
// once for its start position and once per psi hop to a sampled position, with the psi
// store read overlapped, and then through the sample state. A query that is out of range
// is answered from the idle state. After reset, and after every write to sample_rate,
// req_tready stays low while the reciprocal of the rate is rebuilt. The stores are not
// cleared. The front end keeps accepting words into a queue of QUEUE_DEPTH entries, four
// by default, while the engine walks or the result register waits on rsp_tready.
module sampled_suffix_array_lookup #(
   parameter int MAX_ENTRIES = ssal_pkg::MAX_ENTRIES_DEFAULT,
   parameter int QUEUE_DEPTH = ssal_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] position, [31:16] value
   input  logic [ssal_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] kind
   input  logic [ssal_pkg::KIND_W-1:0]        req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] suffix_position
   output logic [ssal_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [ssal_pkg::STATUS_W-1:0]      rsp_tuser,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssal_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ssal_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssal_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [ssal_pkg::RATE_W-1:0]    sample_rate_ff;
   logic [ssal_pkg::TEXT_W-1:0]    text_size_ff;
   logic [ssal_pkg::RATE_W-1:0]    eff_rate;
   logic                           csr_write;
   logic                           csr_reg_sel;
   logic                           rate_write;

   logic                           recip_busy;
   logic [ssal_pkg::RECIP_W-1:0]   recip;

   logic                           push;
   logic                           pop;
   logic                           queue_full;
   logic                           queue_empty;
   ssal_pkg::cmd_type              push_cmd;
   ssal_pkg::cmd_type              head_cmd;

   // Register space: bit 2 of the byte address picks the register.
   assign csr_pready  = 1'b1;
   assign csr_reg_sel = csr_paddr[2];
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rate_write  = csr_write && (csr_reg_sel == ssal_pkg::REG_SAMPLE_RATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= ssal_pkg::SAMPLE_RATE_RESET;
         text_size_ff   <= ssal_pkg::TEXT_SIZE_RESET;
      end else if (csr_write) begin
         case (csr_reg_sel)
            ssal_pkg::REG_SAMPLE_RATE: begin
               sample_rate_ff <= csr_pwdata[ssal_pkg::RATE_W-1:0];
            end
            ssal_pkg::REG_TEXT_SIZE: begin
               text_size_ff <= csr_pwdata[ssal_pkg::TEXT_W-1:0];
            end
            default: begin
               text_size_ff <= text_size_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg_sel)
         ssal_pkg::REG_SAMPLE_RATE: begin
            csr_prdata = ssal_pkg::CSR_DATA_W'(sample_rate_ff);
         end
         ssal_pkg::REG_TEXT_SIZE: begin
            csr_prdata = ssal_pkg::CSR_DATA_W'(text_size_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // A rate of zero behaves as a rate of one.
   assign eff_rate = (sample_rate_ff == '0) ? ssal_pkg::RATE_W'(1) : sample_rate_ff;

   ssal_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (rate_write),
      .rate  (eff_rate),
      .busy  (recip_busy),
      .recip (recip)
   );

   ssal_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .accept_en  (!recip_busy),
      .queue_full (queue_full),
      .text_size  (text_size_ff),
      .push       (push),
      .cmd        (push_cmd)
   );

   ssal_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   ssal_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .empty      (queue_empty),
      .pop        (pop),
      .rate       (eff_rate),
      .recip      (recip),
      .text_size  (text_size_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> dv/sampled_suffix_array_lookup_tb.sv
// Self-checking testbench for the sampled suffix array lookup with psi walk.
`timescale 1ns / 1ps

module sampled_suffix_array_lookup_tb;

   // The predictor keeps full-size copies of both stores. Every entry also has a
   // written flag, because the block gives no defined answer for an entry that was
   // never written. The stimulus only sends queries whose walk stays on written entries.
   localparam int TABLE_SIZE    = ssal_pkg::MAX_ENTRIES_DEFAULT;
   // Random queries whose walk would need more hops than this are not sent. This keeps
   // the run short.
   localparam int STEP_CAP      = 1024;
   // Cycles allowed for loads and psi writes still queued in the block after the last
   // answer has come back. This also covers the reciprocal rebuild after a rate write.
   localparam int SETTLE_CYCLES = 64;

   typedef struct {
      logic [ssal_pkg::POS_W-1:0]    suffix_position;
      logic [ssal_pkg::STATUS_W-1:0] status;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ssal_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] position, [31:16] value
   logic [ssal_pkg::KIND_W-1:0]     req_tuser  = '0;   // [1:0] kind

   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ssal_pkg::RSP_DATA_W-1:0] rsp_tdata;         // [15:0] suffix_position
   logic [ssal_pkg::STATUS_W-1:0]   rsp_tuser;         // [1:0] status

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [ssal_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [ssal_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [ssal_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Predicted state of the block: both stores, the load counter and the registers.
   logic [ssal_pkg::VAL_W-1:0] psi_model [TABLE_SIZE];
   bit                         psi_written [TABLE_SIZE];
   logic [ssal_pkg::VAL_W-1:0] sample_model [TABLE_SIZE];
   bit                         sample_written [TABLE_SIZE];
   int                         loads_taken = 0;
   int                         rate_reg    = 32;
   int                         text_reg    = 65536;

   // Answers predicted for accepted queries, oldest first.
   lookup_type pending_lookups [$];

   int errors        = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;

   sampled_suffix_array_lookup DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // A rate of zero behaves as a rate of one.
   function automatic int active_rate();
      return (rate_reg == 0) ? 1 : rate_reg;
   endfunction

   // Walks psi from the start position until a sampled position is reached and forms
   // the answer. The safe flag drops when the walk would read an entry that was never
   // written or would take more than cap hops; the answer is then meaningless.
   function automatic void walk_lookup(input int start, input int cap,
                                       output lookup_type answer, output bit safe);
      int rate;
      int spot;
      int hops;
      int stored;
      rate = active_rate();
      spot = start;
      hops = 0;
      safe = 1'b1;
      answer.suffix_position = '0;
      answer.status = ssal_pkg::STATUS_OK;
      if (spot >= text_reg || spot >= TABLE_SIZE) begin
         answer.status = ssal_pkg::STATUS_RANGE;
         return;
      end
      while (spot % rate != 0) begin
         // A walk of text_size hops without a sample is abandoned.
         if (hops >= text_reg) begin
            answer.status = ssal_pkg::STATUS_WALK;
            return;
         end
         if (!psi_written[spot] || hops >= cap) begin
            safe = 1'b0;
            return;
         end
         spot = psi_model[spot];
         hops++;
         // A psi target past the text also ends the walk.
         if (spot >= text_reg) begin
            answer.status = ssal_pkg::STATUS_WALK;
            return;
         end
      end
      if (!sample_written[spot / rate]) begin
         safe = 1'b0;
         return;
      end
      stored = sample_model[spot / rate];
      // Subtract the hop count, wrapping modulo the text size. With a text size above
      // 2^16 the result can be wider than the field and is cut to 16 bits.
      stored = (stored < hops) ? text_reg - (hops - stored) : stored - hops;
      answer.suffix_position = stored[ssal_pkg::POS_W-1:0];
   endfunction

   // Applies one accepted word to the predicted state.
   function automatic void predict_word(input ssal_pkg::op_type kind, input int spot,
                                        input int value);
      lookup_type answer;
      bit         safe;
      int         rate;
      rate = active_rate();
      case (kind)
         ssal_pkg::OP_LOAD: begin
            // Loads past the text size are dropped and the counter holds.
            if (loads_taken < text_reg && loads_taken < TABLE_SIZE) begin
               if (loads_taken % rate == 0) begin
                  sample_model[loads_taken / rate] = value[ssal_pkg::VAL_W-1:0];
                  sample_written[loads_taken / rate] = 1'b1;
               end
               loads_taken++;
            end
         end
         ssal_pkg::OP_PSI: begin
            psi_model[spot] = value[ssal_pkg::VAL_W-1:0];
            psi_written[spot] = 1'b1;
         end
         ssal_pkg::OP_QUERY: begin
            walk_lookup(spot, 2 * TABLE_SIZE + 2, answer, safe);
            pending_lookups.push_back(answer);
         end
         default: begin
            // The unused kind has no effect and no answer.
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offers one word, with random idle cycles ahead of it, and waits until it is taken.
   // req_tvalid stays high after the handshake, so that back-to-back words never lower
   // and raise it within one time step.
   task automatic send_word(input ssal_pkg::op_type kind, input int spot, input int value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value[ssal_pkg::VAL_W-1:0], spot[ssal_pkg::POS_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(kind, spot, value);
   endtask

   // Stops offering words and waits until every predicted answer has arrived, then lets
   // queued loads and psi writes finish before anything touches the registers.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register through the APB port, then reads it back.
   task automatic write_register(input logic idx, input int value);
      logic [ssal_pkg::CSR_DATA_W-1:0] seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ssal_pkg::CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      seen = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == ssal_pkg::REG_SAMPLE_RATE) begin
         rate_reg = value;
      end else begin
         text_reg = value;
      end
      if (seen !== ssal_pkg::CSR_DATA_W'(value)) begin
         errors++;
         $display("%0t: register %0d read back: expected %0d, actual %0d",
                  $time, idx, value, seen);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stalls, long hold-offs and checking
   // ---------------------------------------------------------------------------

   // rsp_tready follows the stall rate of the current phase. A test can ask for a long
   // hold-off by loading hold_cycles; it is counted down here one clock at a time.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Each result word is compared field by field with the oldest predicted answer.
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word: expected none, actual %0d status %0d",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata !== want.suffix_position) begin
               errors++;
               $display("%0t: suffix_position: expected %0d, actual %0d",
                        $time, want.suffix_position, rsp_tdata);
            end
            if (rsp_tuser !== want.status) begin
               errors++;
               $display("%0t: status: expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Hand-built text of six entries with a sample every four positions. Covers the
   // field extremes, every kind, a wrapped answer, a psi target past the text, a psi
   // loop that never meets a sample, queries past the text, and a dropped extra load.
   task automatic test_walk_cases();
      write_register(ssal_pkg::REG_SAMPLE_RATE, 4);
      write_register(ssal_pkg::REG_TEXT_SIZE, 6);
      // Samples land at positions 0 and 4; the seventh load is past the text.
      send_word(ssal_pkg::OP_LOAD, 0, 0);
      send_word(ssal_pkg::OP_LOAD, 16'hFFFF, 7);
      send_word(ssal_pkg::OP_LOAD, 0, 1);
      send_word(ssal_pkg::OP_LOAD, 0, 2);
      send_word(ssal_pkg::OP_LOAD, 0, 16'hFFFF);
      send_word(ssal_pkg::OP_LOAD, 0, 3);
      send_word(ssal_pkg::OP_LOAD, 0, 16'h1234);
      send_word(ssal_pkg::OP_PSI, 1, 4);
      send_word(ssal_pkg::OP_PSI, 2, 1);
      send_word(ssal_pkg::OP_PSI, 3, 16'hFFFF);
      send_word(ssal_pkg::OP_PSI, 5, 0);
      send_word(ssal_pkg::OP_PSI, 16'hFFFF, 0);
      send_word(ssal_pkg::OP_QUERY, 0, 0);
      send_word(ssal_pkg::OP_QUERY, 1, 16'hFFFF);
      send_word(ssal_pkg::OP_QUERY, 2, 0);
      send_word(ssal_pkg::OP_QUERY, 5, 0);
      send_word(ssal_pkg::OP_QUERY, 3, 0);
      send_word(ssal_pkg::OP_QUERY, 6, 0);
      send_word(ssal_pkg::OP_QUERY, 16'hFFFF, 0);
      send_word(ssal_pkg::OP_BAD_QUERY, 16'hFFFF, 16'hFFFF);
      // Positions 1 and 2 now point at each other, so the walk circles until it gives up.
      send_word(ssal_pkg::OP_PSI, 1, 2);
      send_word(ssal_pkg::OP_QUERY, 1, 0);
   endtask

   // Register corners: a zero rate, a text size above 2^16 so the wrapped answer is cut
   // to 16 bits, and a text size of zero. The stores survive every register write.
   task automatic test_register_corners();
      wait_drained();
      write_register(ssal_pkg::REG_SAMPLE_RATE, 0);
      send_word(ssal_pkg::OP_QUERY, 1, 0);
      send_word(ssal_pkg::OP_QUERY, 0, 0);
      wait_drained();
      write_register(ssal_pkg::REG_SAMPLE_RATE, 4);
      write_register(ssal_pkg::REG_TEXT_SIZE, 131071);
      send_word(ssal_pkg::OP_QUERY, 5, 0);
      wait_drained();
      write_register(ssal_pkg::REG_TEXT_SIZE, 0);
      send_word(ssal_pkg::OP_LOAD, 0, 16'hAAAA);
      send_word(ssal_pkg::OP_QUERY, 0, 0);
   endtask

   // One random phase under one register setting and one idling mode. Most traffic is
   // well-formed walks: a short psi chain ending on a sampled position that holds a
   // value, then a query at its head. The rest is lone queries, stray psi writes,
   // loads and words of the unused kind.
   task automatic run_phase(input int rate, input int size, input int items,
                            input int idle_pct, input int stall_pct);
      int         span;
      int         step_rate;
      int         sent;
      int         pick;
      int         spot;
      int         target;
      int         land;
      bit         found;
      lookup_type answer;
      wait_drained();
      write_register(ssal_pkg::REG_SAMPLE_RATE, rate);
      write_register(ssal_pkg::REG_TEXT_SIZE, size);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      span = (size < TABLE_SIZE) ? size : TABLE_SIZE;
      step_rate = active_rate();
      sent = 0;
      // New loads continue the text where the counter stands and add samples.
      repeat ($urandom_range(24, 4)) begin
         send_word(ssal_pkg::OP_LOAD, $urandom_range(65535), $urandom_range(65535));
         sent++;
      end
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            land = ($urandom_range(span - 1) / step_rate) * step_rate;
            if (!sample_written[land / step_rate]) land = 0;
            // Now and then the chain ends on a target past the text.
            if (span < TABLE_SIZE && $urandom_range(7) == 0) begin
               land = $urandom_range(65535, span);
            end
            target = land;
            repeat ((step_rate == 1) ? 0 : $urandom_range(6, 1)) begin
               do spot = $urandom_range(span - 1); while (spot % step_rate == 0);
               send_word(ssal_pkg::OP_PSI, spot, target);
               sent++;
               target = spot;
            end
            walk_lookup(target, STEP_CAP, answer, found);
            if (found) begin
               send_word(ssal_pkg::OP_QUERY, target, $urandom_range(65535));
               sent++;
            end
         end else if (pick < 68) begin
            // A lone query at a random position, kept only if its walk is defined.
            found = 1'b0;
            repeat (8) begin
               if (!found) begin
                  spot = ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(span - 1);
                  walk_lookup(spot, STEP_CAP, answer, found);
               end
            end
            if (found) begin
               send_word(ssal_pkg::OP_QUERY, spot, $urandom_range(65535));
               sent++;
            end
         end else if (pick < 82) begin
            spot = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                            : $urandom_range(span - 1);
            target = ($urandom_range(6) == 0) ? $urandom_range(65535)
                                              : $urandom_range(span - 1);
            send_word(ssal_pkg::OP_PSI, spot, target);
            sent++;
         end else if (pick < 96) begin
            send_word(ssal_pkg::OP_LOAD, $urandom_range(65535), $urandom_range(65535));
            sent++;
         end else begin
            send_word(ssal_pkg::OP_BAD_QUERY, $urandom_range(65535), $urandom_range(65535));
         end
      end
   endtask

   // Phases step through the idling modes and through small and extreme settings.
   task automatic test_random_walks();
      run_phase(2, 40, 110, 0, 0);
      run_phase(5, 100, 130, 67, 0);
      run_phase(1, 60, 90, 0, 67);
      run_phase(16, 300, 130, 14, 14);
      run_phase(256, 65536, 90, 0, 0);
      run_phase(511, 131071, 70, 14, 14);
      run_phase(0, 24, 80, 67, 0);
      run_phase(3, 600, 130, 0, 67);
   endtask

   // The result side is held off for a long stretch while queries keep coming, so the
   // input queue fills and req_tready has to drop. Then sending stops until every
   // answer is back, and a short burst runs against a stalling receiver.
   task automatic test_output_backpressure();
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles = 500;
      repeat (16) send_word(ssal_pkg::OP_QUERY, 0, $urandom_range(65535));
      wait_drained();
      rsp_stall_pct = 67;
      repeat (8) send_word(ssal_pkg::OP_QUERY, 0, $urandom_range(65535));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // The block rebuilds its reciprocal after reset; let that finish before the
      // first register write.
      wait_drained();
      test_walk_cases();
      test_register_corners();
      test_random_walks();
      test_output_backpressure();
      wait_drained();
      if (errors == 0) begin
         $display("sampled_suffix_array_lookup test passed");
      end else begin
         $display("sampled_suffix_array_lookup test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #(60_000_000);
      $display("sampled_suffix_array_lookup test failed");
      $finish;
   end

endmodule
